/* hw/rtl/plc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    // Default pool size
    localparam int DEF_CAPACITY = 32;

    // Request opcodes (code 7 has no meaning and is answered with ok)
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_POS   = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_FRONT = 3'd5,
        OP_READ      = 3'd6
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Input transaction
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [6:0]         length;
        logic               last;
    } t_out;

    // Result offered by the controller to the output register
    typedef struct packed {
        logic valid;
        t_out data;
    } t_emit;

    // Controller sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_CONT,
        S_TAKE,
        S_FIX,
        S_MI_L,
        S_MI_W,
        S_DF_NEXT,
        S_DM_V,
        S_DM_L,
        S_GIVE,
        S_RD,
        S_RESP
    } t_state;

    // Resolved kind of list update
    typedef enum logic [2:0] {
        M_INS_FRONT,
        M_INS_END,
        M_INS_MID,
        M_DEL_FRONT,
        M_DEL_END,
        M_DEL_MID
    } t_mode;

endpackage

`default_nettype wire

/* hw/rtl/positional_circular_list.sv */
// Positional circular list: an ordered ring of signed 32-bit values kept in a
// pool of CAPACITY nodes, with next links and a free list in on-chip memory.
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction per
// request carrying opcode, value and 1-based position.
// Output channel (o_out_valid / i_out_stall / o_out_data): every request but a
// read of a non-empty list gives one status transaction; such a read gives one
// transaction per element, head to tail, with last set on the final one.
// Positional updates away from the ends and deletes at the end of a longer
// list walk the links from the head, one link followed per cycle; a read gives
// its elements one per cycle while the output register is free. One request is
// worked on at a time; the next can be taken in the cycle after the last result
// has entered the output register.
// Reset (synchronous, active low) empties the list and restores the free list;
// no clearing pass is needed.
// When the receiver stalls, the output register holds its transaction and the
// controller waits with the next result; input is stalled while busy.
`timescale 1ns / 1ps
`default_nettype none

module positional_circular_list #(
    parameter int CAPACITY = plc_pkg::DEF_CAPACITY
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire plc_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output plc_pkg::t_out     o_out_data
);

    import plc_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    t_emit              emit;
    logic               slot_free;
    logic               r_out_vld;
    t_out               r_out;

    logic               lk_rd_en;
    logic [IW-1:0]      lk_rd_addr;
    logic [IW-1:0]      lk_rd_data;
    logic               lk_wr_en;
    logic [IW-1:0]      lk_wr_addr;
    logic [IW-1:0]      lk_wr_data;
    logic               vl_rd_en;
    logic [IW-1:0]      vl_rd_addr;
    logic signed [31:0] vl_rd_data;
    logic               vl_wr_en;
    logic [IW-1:0]      vl_wr_addr;
    logic signed [31:0] vl_wr_data;

    plc_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .LW       (LW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_emit       (emit),
        .i_slot_free  (slot_free),
        .o_lk_rd_en   (lk_rd_en),
        .o_lk_rd_addr (lk_rd_addr),
        .i_lk_rd_data (lk_rd_data),
        .o_lk_wr_en   (lk_wr_en),
        .o_lk_wr_addr (lk_wr_addr),
        .o_lk_wr_data (lk_wr_data),
        .o_vl_rd_en   (vl_rd_en),
        .o_vl_rd_addr (vl_rd_addr),
        .i_vl_rd_data (vl_rd_data),
        .o_vl_wr_en   (vl_wr_en),
        .o_vl_wr_addr (vl_wr_addr),
        .o_vl_wr_data (vl_wr_data)
    );

    plc_link_mem #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (lk_rd_en),
        .i_rd_addr (lk_rd_addr),
        .o_rd_data (lk_rd_data),
        .i_wr_en   (lk_wr_en),
        .i_wr_addr (lk_wr_addr),
        .i_wr_data (lk_wr_data)
    );

    plc_value_mem #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_value_mem (
        .i_clk     (i_clk),
        .i_rd_en   (vl_rd_en),
        .i_rd_addr (vl_rd_addr),
        .o_rd_data (vl_rd_data),
        .i_wr_en   (vl_wr_en),
        .i_wr_addr (vl_wr_addr),
        .i_wr_data (vl_wr_data)
    );

    // Output register: free when empty or being taken this cycle
    assign slot_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit.valid) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out <= emit.data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* hw/rtl/plc_link_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module plc_link_mem #(
    parameter int CAPACITY = 32,
    parameter int IW       = $clog2(CAPACITY)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [IW-1:0] i_rd_addr,
    output logic      [IW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire logic [IW-1:0] i_wr_data
);

    logic [IW-1:0]       r_mem [CAPACITY];
    logic [CAPACITY-1:0] r_vld;
    logic [IW-1:0]       r_rd_data;
    logic [IW-1:0]       r_rd_addr;
    logic                r_rd_vld;

    // Storage array, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    // Per-entry written flags; cleared entries read as their reset link
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Reset link: entry i points to i+1, the last one wraps to 0
    always_comb begin
        if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else if (r_rd_addr == IW'(CAPACITY - 1)) begin
            o_rd_data = '0;
        end else begin
            o_rd_data = r_rd_addr + 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/plc_value_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module plc_value_mem #(
    parameter int CAPACITY = 32,
    parameter int IW       = $clog2(CAPACITY)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rd_en,
    input  wire logic [IW-1:0]      i_rd_addr,
    output logic signed [31:0]      o_rd_data,
    input  wire logic               i_wr_en,
    input  wire logic [IW-1:0]      i_wr_addr,
    input  wire logic signed [31:0] i_wr_data
);

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;

    // Element store, registered read that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/plc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module plc_ctrl #(
    parameter int CAPACITY = 32,
    parameter int IW       = $clog2(CAPACITY),
    parameter int LW       = $clog2(CAPACITY + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire plc_pkg::t_in       i_in_data,
    output logic                    o_in_stall,
    output plc_pkg::t_emit          o_emit,
    input  wire logic               i_slot_free,
    output logic                    o_lk_rd_en,
    output logic [IW-1:0]           o_lk_rd_addr,
    input  wire logic [IW-1:0]      i_lk_rd_data,
    output logic                    o_lk_wr_en,
    output logic [IW-1:0]           o_lk_wr_addr,
    output logic [IW-1:0]           o_lk_wr_data,
    output logic                    o_vl_rd_en,
    output logic [IW-1:0]           o_vl_rd_addr,
    input  wire logic signed [31:0] i_vl_rd_data,
    output logic                    o_vl_wr_en,
    output logic [IW-1:0]           o_vl_wr_addr,
    output logic signed [31:0]      o_vl_wr_data
);

    import plc_pkg::*;

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    t_status            r_status, n_status;
    logic signed [31:0] r_val, n_val;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_tail, n_tail;
    logic [IW-1:0]      r_free, n_free;
    logic [LW-1:0]      r_len, n_len;
    logic [IW-1:0]      r_cur, n_cur;
    logic [IW-1:0]      r_new, n_new;
    logic [IW-1:0]      r_victim, n_victim;
    logic [LW-1:0]      r_cnt, n_cnt;

    logic               walk_go;
    logic [LW-1:0]      walk_steps;
    logic               take_go;
    logic [8:0]         pos_x;
    logic [8:0]         len_x;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_free  <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_len   <= n_len;
        end
    end

    // Per-request working registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_status <= n_status;
        r_val    <= n_val;
        r_cur    <= n_cur;
        r_new    <= n_new;
        r_victim <= n_victim;
        r_cnt    <= n_cnt;
    end

    assign pos_x        = {1'b0, i_in_data.position};
    assign len_x        = 9'(r_len);
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_vl_rd_addr = o_lk_rd_addr;

    // Sequencer: next state, memory commands and results
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_status   = r_status;
        n_val      = r_val;
        n_head     = r_head;
        n_tail     = r_tail;
        n_free     = r_free;
        n_len      = r_len;
        n_cur      = r_cur;
        n_new      = r_new;
        n_victim   = r_victim;
        n_cnt      = r_cnt;
        walk_go    = 1'b0;
        walk_steps = '0;
        take_go    = 1'b0;

        o_lk_rd_en   = 1'b0;
        o_lk_rd_addr = r_cur;
        o_lk_wr_en   = 1'b0;
        o_lk_wr_addr = r_cur;
        o_lk_wr_data = r_new;
        o_vl_rd_en   = 1'b0;
        o_vl_wr_en   = 1'b0;
        o_vl_wr_addr = r_free;
        o_vl_wr_data = r_val;
        o_emit       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val    = i_in_data.value;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    unique case (i_in_data.opcode)
                        OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
                            if (r_len == LW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (i_in_data.opcode == OP_INS_POS &&
                                         (pos_x == 9'd0 || pos_x > len_x + 9'd1)) begin
                                n_status = ST_BAD_POS;
                            end else if (i_in_data.opcode == OP_INS_FRONT ||
                                         (i_in_data.opcode == OP_INS_POS &&
                                          pos_x == 9'd1)) begin
                                n_mode  = M_INS_FRONT;
                                take_go = 1'b1;
                            end else if (i_in_data.opcode == OP_INS_END ||
                                         pos_x == len_x + 9'd1) begin
                                n_mode  = M_INS_END;
                                take_go = 1'b1;
                            end else begin
                                n_mode     = M_INS_MID;
                                walk_go    = 1'b1;
                                walk_steps = LW'(pos_x - 9'd2);
                            end
                        end
                        OP_DEL_POS, OP_DEL_END, OP_DEL_FRONT: begin
                            if (r_len == '0) begin
                                n_status = ST_EMPTY;
                            end else if (i_in_data.opcode == OP_DEL_POS &&
                                         (pos_x == 9'd0 || pos_x > len_x)) begin
                                n_status = ST_BAD_POS;
                            end else if (i_in_data.opcode == OP_DEL_FRONT ||
                                         (i_in_data.opcode == OP_DEL_POS &&
                                          pos_x == 9'd1)) begin
                                n_victim = r_head;
                                if (r_len == LW'(1)) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_len   = '0;
                                    n_state = S_GIVE;
                                end else begin
                                    o_lk_rd_en   = 1'b1;
                                    o_lk_rd_addr = r_head;
                                    n_state      = S_DF_NEXT;
                                end
                            end else if (i_in_data.opcode == OP_DEL_END ||
                                         pos_x == len_x) begin
                                n_victim = r_tail;
                                if (r_len == LW'(1)) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_len   = '0;
                                    n_state = S_GIVE;
                                end else begin
                                    n_mode     = M_DEL_END;
                                    walk_go    = 1'b1;
                                    walk_steps = r_len - LW'(2);
                                end
                            end else begin
                                n_mode     = M_DEL_MID;
                                walk_go    = 1'b1;
                                walk_steps = LW'(pos_x - 9'd2);
                            end
                        end
                        OP_READ: begin
                            if (r_len == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_lk_rd_en   = 1'b1;
                                o_vl_rd_en   = 1'b1;
                                o_lk_rd_addr = r_head;
                                n_cnt        = r_len;
                                n_state      = S_RD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase

                    // Take a node off the free list and store the value
                    if (take_go) begin
                        o_lk_rd_en   = 1'b1;
                        o_lk_rd_addr = r_free;
                        o_vl_wr_en   = 1'b1;
                        o_vl_wr_addr = r_free;
                        o_vl_wr_data = i_in_data.value;
                        n_new        = r_free;
                        n_state      = S_TAKE;
                    end

                    // Start a walk from the head
                    if (walk_go) begin
                        n_cur = r_head;
                        if (walk_steps == '0) begin
                            n_state = S_CONT;
                        end else begin
                            o_lk_rd_en   = 1'b1;
                            o_lk_rd_addr = r_head;
                            n_cnt        = walk_steps;
                            n_state      = S_WALK;
                        end
                    end
                end
            end

            // One link per cycle
            S_WALK: begin
                n_cur = i_lk_rd_data;
                if (r_cnt == LW'(1)) begin
                    n_state = S_CONT;
                end else begin
                    o_lk_rd_en   = 1'b1;
                    o_lk_rd_addr = i_lk_rd_data;
                    n_cnt        = r_cnt - 1'b1;
                end
            end

            // Walk done, r_cur is the predecessor
            S_CONT: begin
                unique case (r_mode)
                    M_INS_MID: begin
                        o_lk_rd_en   = 1'b1;
                        o_lk_rd_addr = r_free;
                        o_vl_wr_en   = 1'b1;
                        n_new        = r_free;
                        n_state      = S_TAKE;
                    end
                    M_DEL_END: begin
                        o_lk_wr_en   = 1'b1;
                        o_lk_wr_data = r_head;
                        n_tail       = r_cur;
                        n_len        = r_len - 1'b1;
                        n_state      = S_GIVE;
                    end
                    M_DEL_MID: begin
                        o_lk_rd_en = 1'b1;
                        n_state    = S_DM_V;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // Link of the taken node is the new free head
            S_TAKE: begin
                n_free = i_lk_rd_data;
                if (r_mode == M_INS_MID) begin
                    o_lk_rd_en = 1'b1;
                    n_state    = S_MI_L;
                end else if (r_len == '0) begin
                    o_lk_wr_en   = 1'b1;
                    o_lk_wr_addr = r_new;
                    n_head       = r_new;
                    n_tail       = r_new;
                    n_len        = r_len + 1'b1;
                    n_state      = S_RESP;
                end else begin
                    o_lk_wr_en   = 1'b1;
                    o_lk_wr_addr = r_new;
                    o_lk_wr_data = r_head;
                    n_state      = S_FIX;
                end
            end

            // Close the ring through the new node
            S_FIX: begin
                o_lk_wr_en   = 1'b1;
                o_lk_wr_addr = r_tail;
                if (r_mode == M_INS_FRONT) begin
                    n_head = r_new;
                end else begin
                    n_tail = r_new;
                end
                n_len   = r_len + 1'b1;
                n_state = S_RESP;
            end

            S_MI_L: begin
                o_lk_wr_en   = 1'b1;
                o_lk_wr_addr = r_new;
                o_lk_wr_data = i_lk_rd_data;
                n_state      = S_MI_W;
            end

            S_MI_W: begin
                o_lk_wr_en = 1'b1;
                n_len      = r_len + 1'b1;
                n_state    = S_RESP;
            end

            // Front delete: successor of the old head
            S_DF_NEXT: begin
                o_lk_wr_en   = 1'b1;
                o_lk_wr_addr = r_tail;
                o_lk_wr_data = i_lk_rd_data;
                n_head       = i_lk_rd_data;
                n_len        = r_len - 1'b1;
                n_state      = S_GIVE;
            end

            // Middle delete: victim and its successor
            S_DM_V: begin
                n_victim     = i_lk_rd_data;
                o_lk_rd_en   = 1'b1;
                o_lk_rd_addr = i_lk_rd_data;
                n_state      = S_DM_L;
            end

            S_DM_L: begin
                o_lk_wr_en   = 1'b1;
                o_lk_wr_data = i_lk_rd_data;
                n_len        = r_len - 1'b1;
                n_state      = S_GIVE;
            end

            // Return the victim to the free list
            S_GIVE: begin
                o_lk_wr_en   = 1'b1;
                o_lk_wr_addr = r_victim;
                o_lk_wr_data = r_free;
                n_free       = r_victim;
                n_state      = S_RESP;
            end

            // List read: one element per free output slot
            S_RD: begin
                if (i_slot_free) begin
                    o_emit.valid        = 1'b1;
                    o_emit.data.status  = ST_OK;
                    o_emit.data.element = i_vl_rd_data;
                    o_emit.data.length  = 7'(r_len);
                    o_emit.data.last    = (r_cnt == LW'(1));
                    if (r_cnt == LW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        o_lk_rd_en   = 1'b1;
                        o_vl_rd_en   = 1'b1;
                        o_lk_rd_addr = i_lk_rd_data;
                        n_cnt        = r_cnt - 1'b1;
                    end
                end
            end

            // Single status result
            S_RESP: begin
                if (i_slot_free) begin
                    o_emit.valid        = 1'b1;
                    o_emit.data.status  = r_status;
                    o_emit.data.element = '0;
                    o_emit.data.length  = 7'(r_len);
                    o_emit.data.last    = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    import plc_pkg::*;

    localparam int POOL           = plc_pkg::DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 480;

    // Opcode with no defined meaning, answered with ok
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Random phase flavors
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    // Pending requests, list contents as predicted, results still owed
    t_in                req_q[$];
    logic signed [31:0] ring_vals[$];
    t_out               owed_results[$];

    int          gen_len = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned cyc = 0;

    positional_circular_list #(
        .CAPACITY(POOL)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length for either side; one window in four of the cycle counter runs flat out
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (((cyc / 400) % 4) == 0) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // List length after a request, used only to steer stimulus
    function automatic int len_after(logic [2:0] op, int p, int n);
        case (op)
            OP_INS_FRONT, OP_INS_END: return (n < POOL) ? n + 1 : n;
            OP_INS_POS: return (n < POOL && p >= 1 && p <= n + 1) ? n + 1 : n;
            OP_DEL_POS: return (n > 0 && p >= 1 && p <= n) ? n - 1 : n;
            OP_DEL_END, OP_DEL_FRONT: return (n > 0) ? n - 1 : n;
            default: return n;
        endcase
    endfunction

    task automatic add_item(logic [2:0] op, logic [31:0] v, int p);
        t_in req;
        req.opcode   = op;
        req.value    = v;
        req.position = p[7:0];
        req_q.push_back(req);
        gen_len = len_after(op, p, gen_len);
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'h7FFF_FFFF;
        if (r < 10) return 32'h8000_0000;
        if (r < 13) return 32'h0;
        if (r < 16) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Out-of-range position above a given limit, or zero
    function automatic int bad_pos(int limit);
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(limit + 1, 255);
    endfunction

    // List behavior: updates the predicted contents and queues the results owed
    task automatic apply_request(t_in req);
        int      n;
        int      p;
        int      k;
        t_status st;
        t_out    res;
        n  = ring_vals.size();
        p  = req.position;
        st = ST_OK;
        case (req.opcode)
            OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
                // full pool takes priority over a bad position
                if (n >= POOL) st = ST_FULL;
                else if (req.opcode == OP_INS_FRONT) ring_vals.push_front(req.value);
                else if (req.opcode == OP_INS_END) ring_vals.push_back(req.value);
                else if (p < 1 || p > n + 1) st = ST_BAD_POS;
                else ring_vals.insert(p - 1, req.value);
            end
            OP_DEL_POS, OP_DEL_END, OP_DEL_FRONT: begin
                if (n == 0) st = ST_EMPTY;
                else if (req.opcode == OP_DEL_END) ring_vals.pop_back();
                else if (req.opcode == OP_DEL_FRONT) ring_vals.pop_front();
                else if (p < 1 || p > n) st = ST_BAD_POS;
                else ring_vals.delete(p - 1);
            end
            OP_READ: begin
                if (n == 0) begin
                    st = ST_EMPTY;
                end else begin
                    // one transaction per element, head to tail
                    for (k = 0; k < n; k++) begin
                        res.status  = ST_OK;
                        res.element = ring_vals[k];
                        res.length  = n[6:0];
                        res.last    = (k == n - 1);
                        owed_results.push_back(res);
                    end
                    return;
                end
            end
            default: ;
        endcase
        res.status  = st;
        res.element = '0;
        res.length  = 7'(ring_vals.size());
        res.last    = 1'b1;
        owed_results.push_back(res);
    endtask

    task automatic check_result(t_out got);
        t_out want;
        if (owed_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected transaction: status %0d element %0d length %0d last %0d",
                         got.status, got.element, got.length, got.last);
        end else begin
            want = owed_results.pop_front();
            if (got.status !== want.status || got.element !== want.element ||
                got.length !== want.length || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected status %0d element %0d length %0d last %0d, ",
                              "got status %0d element %0d length %0d last %0d"},
                             want.status, want.element, want.length, want.last,
                             got.status, got.element, got.length, got.last);
            end
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) apply_request(i_in_data);
            if (i_in_valid && o_in_stall) begin
                // stalled: hold the transaction
            end else if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= req_q.pop_front();
                send_gap   <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= stall_left - 1;
            end else if ($urandom_range(0, 99) < 25) begin
                i_out_stall <= 1'b1;
                stall_left  <= pick_gap();
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Progress counter for the watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[positional_circular_list] ERROR");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int         mode;
        int         span;
        int         ins_share;
        int         r;
        int         p;
        int         n_random;
        logic [2:0] op;

        // directed: empty list, bad positions, extremes, every opcode
        add_item(OP_READ,      32'h0, 0);
        add_item(OP_DEL_FRONT, 32'h0, 0);
        add_item(OP_DEL_END,   32'h0, 0);
        add_item(OP_DEL_POS,   32'h0, 1);
        add_item(OP_INS_POS,   32'h1234_5678, 0);
        add_item(OP_INS_POS,   32'h1234_5678, 2);
        add_item(OP_INS_POS,   32'h7FFF_FFFF, 1);
        add_item(OP_INS_FRONT, 32'h8000_0000, 0);
        add_item(OP_INS_END,   32'hFFFF_FFFF, 255);
        add_item(OP_INS_POS,   32'h0, 4);
        add_item(OP_INS_POS,   32'd12345, 3);
        add_item(OP_INS_POS,   32'hA5A5_5A5A, 255);
        add_item(OP_READ,      32'hFFFF_FFFF, 255);
        add_item(OP_DEL_POS,   32'h0, 0);
        add_item(OP_DEL_POS,   32'h0, 6);
        add_item(OP_DEL_POS,   32'h0, 255);
        add_item(OP_DEL_POS,   32'h0, 3);
        add_item(OP_DEL_POS,   32'h0, 4);
        add_item(OP_DEL_POS,   32'h0, 1);
        add_item(OP_UNUSED,    32'hFFFF_FFFF, 255);
        add_item(OP_READ,      32'h0, 0);
        add_item(OP_DEL_END,   32'h0, 0);
        add_item(OP_DEL_FRONT, 32'h0, 0);
        add_item(OP_INS_END,   32'd5, 0);
        add_item(OP_READ,      32'h0, 0);

        // random phases that grow, shrink or churn the list
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            mode = $urandom_range(PH_GROW, PH_MIXED);
            span = $urandom_range(20, 60);
            if (span > RANDOM_ITEMS - n_random) span = RANDOM_ITEMS - n_random;
            ins_share = (mode == PH_GROW) ? 72 : (mode == PH_SHRINK) ? 18 : 45;
            repeat (span) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    add_item(OP_READ, pick_value(), $urandom_range(0, 255));
                end else if (r < 11) begin
                    add_item(OP_UNUSED, pick_value(), $urandom_range(0, 255));
                end else if (r < 11 + ins_share) begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_INS_FRONT;
                        1:       op = OP_INS_END;
                        default: op = OP_INS_POS;
                    endcase
                    if (op != OP_INS_POS) p = $urandom_range(0, 255);
                    else if ($urandom_range(0, 99) < 88) p = $urandom_range(1, gen_len + 1);
                    else p = bad_pos(gen_len + 1);
                    add_item(op, pick_value(), p);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       op = OP_DEL_END;
                        1:       op = OP_DEL_FRONT;
                        default: op = OP_DEL_POS;
                    endcase
                    if (op != OP_DEL_POS) p = $urandom_range(0, 255);
                    else if (gen_len > 0 && $urandom_range(0, 99) < 88)
                        p = $urandom_range(1, gen_len);
                    else p = bad_pos(gen_len);
                    add_item(op, pick_value(), p);
                end
            end
            n_random += span;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0)
            $display("[positional_circular_list] OK");
        else
            $display("[positional_circular_list] ERROR");
        $finish;
    end

endmodule
